[rtl/per_source_fixed_window_limiter_top_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the per-source fixed-window limiter
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef PER_SOURCE_FIXED_WINDOW_LIMITER_TOP_DEFINES_SVH
`define PER_SOURCE_FIXED_WINDOW_LIMITER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// ante implies cons in the same cycle
`define FWL_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// cond implies nxt in the following cycle
`define FWL_ASSERT_NEXT(lbl, clk, rst, cond, nxt, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) \
      else $error(msg);
// cond never holds
`define FWL_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);
`else
`define FWL_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define FWL_ASSERT_NEXT(lbl, clk, rst, cond, nxt, msg)
`define FWL_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

[rtl/fwl_pkg.sv]
// ----------------------------------------------------------------------------
// fwl_pkg
// Types and constants shared by the fixed-window limiter modules.
// ----------------------------------------------------------------------------
package fwl_pkg;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PER_WINDOW = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SECONDS = 1'b1;

   localparam logic [7:0]  MAX_PER_WINDOW_RESET = 8'd10;
   localparam logic [15:0] WINDOW_SECONDS_RESET = 16'd60;

   typedef struct packed {
      logic [31:0] source_address;
      logic [31:0] now_seconds;
   } req_type;

   typedef struct packed {
      logic       allowed;
      logic [7:0] count_in_window;
      logic       table_full;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  max_per_window;
      logic [15:0] window_seconds;
   } cfg_type;

   typedef struct packed {
      logic clearing;
      logic walking;
   } stat_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] source;
      logic [31:0] window_start;
      logic [7:0]  count;
   } entry_type;

endpackage

[rtl/fwl_fifo.sv]
// ----------------------------------------------------------------------------
// fwl_fifo
// Two-entry queue; decouples the request side, the table engine and the
// result side.
// ----------------------------------------------------------------------------
module fwl_fifo #(
   parameter int WIDTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int DEPTH = 2;

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == 2'(DEPTH));
   assign empty   = (count_ff == 2'd0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rdata   = slot_ff[rd_ptr_ff];

   always_comb begin
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

[rtl/fwl_engine.sv]
// ----------------------------------------------------------------------------
// fwl_engine
// Table engine: walks every entry once per request, frees expired windows,
// finds the source or the lowest free entry, then updates at most one entry.
// ----------------------------------------------------------------------------
module fwl_engine import fwl_pkg::*; #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     req_empty,
   input  req_type  req_data,
   output logic     req_pop,
   input  logic     rsp_full,
   output logic     rsp_push,
   output rsp_type  rsp_data,
   output stat_type status
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [IDX_W:0]   NUM_ENTRY = (IDX_W+1)'(TABLE_ENTRIES);

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_WALK   = 4'b0100,
      ST_UPDATE = 4'b1000
   } state_type;

   entry_type table_mem [TABLE_ENTRIES];

   state_type        state_ff,     state_in;
   logic [IDX_W-1:0] clr_ff,       clr_in;
   logic [IDX_W:0]   issue_ff,     issue_in;
   logic             chk_vld_ff,   chk_vld_in;
   logic [IDX_W-1:0] chk_idx_ff,   chk_idx_in;
   req_type          cur_ff,       cur_in;
   logic             found_ff,     found_in;
   logic [IDX_W-1:0] hit_idx_ff,   hit_idx_in;
   logic [31:0]      hit_start_ff, hit_start_in;
   logic [7:0]       hit_count_ff, hit_count_in;
   logic             have_free_ff, have_free_in;
   logic [IDX_W-1:0] free_idx_ff,  free_idx_in;
   entry_type        rd_data_ff;

   logic [IDX_W-1:0] rd_addr;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   entry_type        mem_wdata;
   logic [31:0]      elapsed;
   logic             expired;
   logic             live;

   // wrapping elapsed time against the registered read of the checked entry
   assign elapsed = cur_ff.now_seconds - rd_data_ff.window_start;
   assign expired = (elapsed >= {16'd0, cfg.window_seconds});
   assign live    = rd_data_ff.valid & ~expired;
   assign rd_addr = issue_ff[IDX_W-1:0];

   assign status.clearing = (state_ff == ST_CLEAR);
   assign status.walking  = (state_ff == ST_WALK);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      issue_in     = issue_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      cur_in       = cur_ff;
      found_in     = found_ff;
      hit_idx_in   = hit_idx_ff;
      hit_start_in = hit_start_ff;
      hit_count_in = hit_count_ff;
      have_free_in = have_free_ff;
      free_idx_in  = free_idx_ff;
      req_pop      = 1'b0;
      rsp_push     = 1'b0;
      rsp_data     = '0;
      mem_we       = 1'b0;
      mem_waddr    = clr_ff;
      mem_wdata    = '0;

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            issue_in     = '0;
            found_in     = 1'b0;
            have_free_in = 1'b0;
            if (!req_empty && !rsp_full) begin
               req_pop  = 1'b1;
               cur_in   = req_data;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (issue_ff < NUM_ENTRY) begin
               issue_in   = issue_ff + 1'b1;
               chk_vld_in = 1'b1;
               chk_idx_in = rd_addr;
            end
            if (chk_vld_ff) begin
               // free an expired window on the way past
               if (rd_data_ff.valid && expired) begin
                  mem_we          = 1'b1;
                  mem_waddr       = chk_idx_ff;
                  mem_wdata       = rd_data_ff;
                  mem_wdata.valid = 1'b0;
               end
               if (live && !found_ff &&
                   (rd_data_ff.source == cur_ff.source_address)) begin
                  found_in     = 1'b1;
                  hit_idx_in   = chk_idx_ff;
                  hit_start_in = rd_data_ff.window_start;
                  hit_count_in = rd_data_ff.count;
               end
               if (!live && !have_free_ff) begin
                  have_free_in = 1'b1;
                  free_idx_in  = chk_idx_ff;
               end
               if (chk_idx_ff == LAST_IDX) begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            rsp_push = 1'b1;
            state_in = ST_IDLE;
            if (found_ff) begin
               if (hit_count_ff >= cfg.max_per_window) begin
                  rsp_data.allowed         = 1'b0;
                  rsp_data.count_in_window = hit_count_ff;
               end else begin
                  rsp_data.allowed          = 1'b1;
                  rsp_data.count_in_window  = hit_count_ff + 8'd1;
                  mem_we                    = 1'b1;
                  mem_waddr                 = hit_idx_ff;
                  mem_wdata.valid           = 1'b1;
                  mem_wdata.source          = cur_ff.source_address;
                  mem_wdata.window_start    = hit_start_ff;
                  mem_wdata.count           = hit_count_ff + 8'd1;
               end
            end else if (have_free_ff) begin
               rsp_data.allowed         = 1'b1;
               rsp_data.count_in_window = 8'd1;
               mem_we                   = 1'b1;
               mem_waddr                = free_idx_ff;
               mem_wdata.valid          = 1'b1;
               mem_wdata.source         = cur_ff.source_address;
               mem_wdata.window_start   = cur_ff.now_seconds;
               mem_wdata.count          = 8'd1;
            end else begin
               rsp_data.table_full = 1'b1;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         issue_ff     <= '0;
         chk_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         have_free_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         issue_ff     <= issue_in;
         chk_vld_ff   <= chk_vld_in;
         found_ff     <= found_in;
         have_free_ff <= have_free_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff   <= chk_idx_in;
      cur_ff       <= cur_in;
      hit_idx_ff   <= hit_idx_in;
      hit_start_ff <= hit_start_in;
      hit_count_ff <= hit_count_in;
      free_idx_ff  <= free_idx_in;
   end

   // table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

endmodule

[rtl/per_source_fixed_window_limiter_top.sv]
// ----------------------------------------------------------------------------
// per_source_fixed_window_limiter_top
// Per-source fixed-window connection limiter with a table of sources.
//
// Channel   Direction  Handshake              Payload
// req       in         req_push / req_full    req_type  (source, now)
// rsp       out        rsp_pop / rsp_empty    rsp_type  (allowed, count, full)
// csr       in         csr_write_en           csr_index, csr_wdata
//
// Each transaction makes one pass over the table memory's single read port
// in the table engine, then passes through the update state.
// After reset a clearing pass over every table entry runs before the
// first request is taken; csr writes are taken during it.
// Two-entry queues on each side let requests and results wait while the
// engine works.
// ----------------------------------------------------------------------------
`include "per_source_fixed_window_limiter_top_defines.svh"

module per_source_fixed_window_limiter_top import fwl_pkg::*; #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  req_type               req_data,
   output logic                  req_full,
   input  logic                  rsp_pop,
   output rsp_type               rsp_data,
   output logic                  rsp_empty,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [7:0]  max_per_window_ff, max_per_window_in;
   logic [15:0] window_seconds_ff, window_seconds_in;

   cfg_type  cfg;
   stat_type eng_stat;
   logic     req_q_empty;
   logic     req_q_pop;
   req_type  req_q_data;
   logic     rsp_q_full;
   logic     rsp_q_push;
   rsp_type  rsp_q_data;

   always_comb begin
      max_per_window_in = max_per_window_ff;
      window_seconds_in = window_seconds_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_MAX_PER_WINDOW: max_per_window_in = csr_wdata[7:0];
            CSR_WINDOW_SECONDS: window_seconds_in = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_per_window_ff <= MAX_PER_WINDOW_RESET;
         window_seconds_ff <= WINDOW_SECONDS_RESET;
      end else begin
         max_per_window_ff <= max_per_window_in;
         window_seconds_ff <= window_seconds_in;
      end
   end

   assign cfg.max_per_window = max_per_window_ff;
   assign cfg.window_seconds = window_seconds_ff;

   fwl_fifo #(
      .WIDTH ($bits(req_type))
   ) u_req_q (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (req_data),
      .full  (req_full),
      .pop   (req_q_pop),
      .rdata (req_q_data),
      .empty (req_q_empty)
   );

   fwl_engine #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_empty (req_q_empty),
      .req_data  (req_q_data),
      .req_pop   (req_q_pop),
      .rsp_full  (rsp_q_full),
      .rsp_push  (rsp_q_push),
      .rsp_data  (rsp_q_data),
      .status    (eng_stat)
   );

   fwl_fifo #(
      .WIDTH ($bits(rsp_type))
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_q_push),
      .wdata (rsp_q_data),
      .full  (rsp_q_full),
      .pop   (rsp_pop),
      .rdata (rsp_data),
      .empty (rsp_empty)
   );

   `FWL_ASSERT_IMPL(a_no_take_while_clearing, clock, reset, req_q_pop,
      !eng_stat.clearing, "request taken during clearing pass")
   `FWL_ASSERT_NEVER(a_no_push_when_full, clock, reset,
      rsp_q_push && rsp_q_full, "result pushed into full queue")
   `FWL_ASSERT_NEVER(a_one_at_a_time, clock, reset,
      rsp_q_push && req_q_pop, "request taken while result pushed")
   `FWL_ASSERT_NEXT(a_single_result, clock, reset, rsp_q_push,
      !rsp_q_push && !eng_stat.walking, "back to back results from engine")

endmodule

[tb/per_source_fixed_window_limiter_top_tb.sv]
// ----------------------------------------------------------------------------
// per_source_fixed_window_limiter_top_tb
// Self-checking bench for the per-source fixed-window limiter. A directed
// table covers the field extremes, wrapped elapsed time, the window
// boundary, refusal, zero-valued registers and masking. Random phases
// follow: filling the table until refusal, small source pools over moving
// time, one source counted up to the top limit, and pure noise. Each
// transaction is predicted by a local table model and checked in order.
// ----------------------------------------------------------------------------
module per_source_fixed_window_limiter_top_tb;
   import fwl_pkg::*;

   localparam int          TABLE_ENTRIES = 64;
   localparam int unsigned ITEMS_TOTAL   = 850;
   localparam int unsigned HOLD_CYCLES   = 600;
   localparam int unsigned CYCLE_LIMIT   = 500000;
   localparam int unsigned PRINT_CAP     = 200;
   localparam int          PLAN_ROWS     = 25;

   typedef enum logic { ROW_REQ, ROW_CSR } row_kind_type;
   typedef enum int { SC_FILL, SC_POOL, SC_HAMMER, SC_NOISE } scenario_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] wdata;
      req_type               req;
      logic                  typed;
      rsp_type               want;
   } plan_row_type;

   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  req_push     = 1'b0;
   req_type               req_data     = '0;
   logic                  req_full;
   logic                  rsp_pop      = 1'b0;
   rsp_type               rsp_data;
   logic                  rsp_empty;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index    = CSR_MAX_PER_WINDOW;
   logic [CSR_DATA_W-1:0] csr_wdata    = '0;

   // local copy of the block's table and registers
   logic        tab_valid [TABLE_ENTRIES] = '{default: 1'b0};
   logic [31:0] tab_src   [TABLE_ENTRIES];
   logic [31:0] tab_start [TABLE_ENTRIES];
   logic [7:0]  tab_count [TABLE_ENTRIES];
   logic [7:0]  max_hits = MAX_PER_WINDOW_RESET;
   logic [15:0] win_len  = WINDOW_SECONDS_RESET;

   rsp_type     pending_verdicts [$];
   int unsigned mismatches  = 0;
   int unsigned sent        = 0;
   int unsigned cycle_count = 0;
   bit          no_gaps     = 1'b0;
   bit          hold_rsp    = 1'b0;

   plan_row_type plan [PLAN_ROWS] = '{
      // defaults: limit 10, window 60
      '{ROW_REQ, CSR_MAX_PER_WINDOW, 16'h0000, '{32'h0000_0000, 32'h0000_0000},
        1'b1, '{1'b1, 8'd1, 1'b0}},
      '{ROW_REQ, CSR_MAX_PER_WINDOW, 16'h0000, '{32'hFFFF_FFFF, 32'hFFFF_FFFF},
        1'b1, '{1'b1, 8'd1, 1'b0}},
      // elapsed wraps through zero: 59 seconds, still inside
      '{ROW_REQ, CSR_MAX_PER_WINDOW, 16'h0000, '{32'hFFFF_FFFF, 32'h0000_003A},
        1'b0, '0},
      '{ROW_REQ, CSR_MAX_PER_WINDOW, 16'h0000, '{32'h0000_0000, 32'h0000_003A},
        1'b0, '0},
      // upper byte must be masked off
      '{ROW_CSR, CSR_MAX_PER_WINDOW, 16'hFF02, '0, 1'b0, '0},
      '{ROW_REQ, CSR_MAX_PER_WINDOW, 16'h0000, '{32'hFFFF_FFFF, 32'h0000_003A},
        1'b1, '{1'b0, 8'd2, 1'b0}},
      // exactly one window later: restart
      '{ROW_REQ, CSR_MAX_PER_WINDOW, 16'h0000, '{32'hFFFF_FFFF, 32'h0000_003B},
        1'b0, '0},
      '{ROW_REQ, CSR_MAX_PER_WINDOW, 16'h0000, '{32'h0000_0000, 32'h0000_003B},
        1'b0, '0},
      '{ROW_REQ, CSR_MAX_PER_WINDOW, 16'h0000, '{32'h0000_0000, 32'h0000_003C},
        1'b0, '0},
      // zero limit: new sources pass, known ones are refused
      '{ROW_CSR, CSR_MAX_PER_WINDOW, 16'hFF00, '0, 1'b0, '0},
      '{ROW_REQ, CSR_MAX_PER_WINDOW, 16'h0000, '{32'h1234_5678, 32'h0000_003C},
        1'b1, '{1'b1, 8'd1, 1'b0}},
      '{ROW_REQ, CSR_MAX_PER_WINDOW, 16'h0000, '{32'h1234_5678, 32'h0000_003C},
        1'b1, '{1'b0, 8'd1, 1'b0}},
      // zero window: everything expires on each request
      '{ROW_CSR, CSR_WINDOW_SECONDS, 16'h0000, '0, 1'b0, '0},
      '{ROW_REQ, CSR_MAX_PER_WINDOW, 16'h0000, '{32'h1234_5678, 32'h0000_003C},
        1'b1, '{1'b1, 8'd1, 1'b0}},
      '{ROW_REQ, CSR_MAX_PER_WINDOW, 16'h0000, '{32'h1234_5678, 32'h0000_003C},
        1'b1, '{1'b1, 8'd1, 1'b0}},
      '{ROW_CSR, CSR_WINDOW_SECONDS, 16'hFFFF, '0, 1'b0, '0},
      '{ROW_CSR, CSR_MAX_PER_WINDOW, 16'h00FF, '0, 1'b0, '0},
      '{ROW_REQ, CSR_MAX_PER_WINDOW, 16'h0000, '{32'hA5A5_A5A5, 32'h5A5A_5A5A},
        1'b1, '{1'b1, 8'd1, 1'b0}},
      '{ROW_REQ, CSR_MAX_PER_WINDOW, 16'h0000, '{32'hA5A5_A5A5, 32'h5A5B_5A58},
        1'b0, '0},
      '{ROW_REQ, CSR_MAX_PER_WINDOW, 16'h0000, '{32'hA5A5_A5A5, 32'h5A5B_5A59},
        1'b0, '0},
      '{ROW_CSR, CSR_MAX_PER_WINDOW, 16'h0001, '0, 1'b0, '0},
      '{ROW_CSR, CSR_WINDOW_SECONDS, 16'h0001, '0, 1'b0, '0},
      '{ROW_REQ, CSR_MAX_PER_WINDOW, 16'h0000, '{32'h5A5A_5A5A, 32'h0000_0000},
        1'b0, '0},
      '{ROW_REQ, CSR_MAX_PER_WINDOW, 16'h0000, '{32'h5A5A_5A5A, 32'h0000_0000},
        1'b0, '0},
      '{ROW_REQ, CSR_MAX_PER_WINDOW, 16'h0000, '{32'h5A5A_5A5A, 32'h0000_0001},
        1'b0, '0}
   };

   per_source_fixed_window_limiter_top #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_data    (req_data),
      .req_full    (req_full),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .rsp_empty   (rsp_empty),
      .csr_write_en(csr_write_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // sweep expired entries, then look up or allocate, as the block does
   function automatic rsp_type admit_request(input req_type r);
      rsp_type     v;
      int          hit;
      int          free_idx;
      logic [31:0] elapsed;
      v        = '0;
      hit      = -1;
      free_idx = -1;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (tab_valid[i]) begin
            elapsed = r.now_seconds - tab_start[i];
            if (elapsed >= {16'd0, win_len}) tab_valid[i] = 1'b0;
         end
      end
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (tab_valid[i]) begin
            if (hit < 0 && tab_src[i] == r.source_address) hit = i;
         end else if (free_idx < 0) begin
            free_idx = i;
         end
      end
      if (hit >= 0) begin
         if (tab_count[hit] < max_hits) begin
            tab_count[hit] = tab_count[hit] + 8'd1;
            v.allowed      = 1'b1;
         end
         v.count_in_window = tab_count[hit];
      end else if (free_idx >= 0) begin
         tab_valid[free_idx] = 1'b1;
         tab_src[free_idx]   = r.source_address;
         tab_start[free_idx] = r.now_seconds;
         tab_count[free_idx] = 8'd1;
         v.allowed           = 1'b1;
         v.count_in_window   = 8'd1;
      end else begin
         v.table_full = 1'b1;
      end
      return v;
   endfunction

   task automatic flag_mismatch(input string what, input int unsigned got,
                                input int unsigned want);
      if (mismatches < PRINT_CAP)
         $display("mismatch: %s got %0h want %0h at cycle %0d",
                  what, got, want, cycle_count);
      mismatches++;
   endtask

   task automatic check_verdict(input rsp_type got);
      rsp_type want;
      if (pending_verdicts.size() == 0) begin
         flag_mismatch("result with nothing pending", 32'(got), 0);
      end else begin
         want = pending_verdicts.pop_front();
         if (got.allowed !== want.allowed)
            flag_mismatch("allowed", 32'(got.allowed), 32'(want.allowed));
         if (got.count_in_window !== want.count_in_window)
            flag_mismatch("count_in_window", 32'(got.count_in_window),
                          32'(want.count_in_window));
         if (got.table_full !== want.table_full)
            flag_mismatch("table_full", 32'(got.table_full), 32'(want.table_full));
      end
   endtask

   // leaves req_push high; the caller lowers it or offers again at once
   task automatic offer(input req_type r, input logic typed, input rsp_type want);
      int unsigned gap;
      rsp_type     v;
      gap = no_gaps ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_full !== 1'b0) @(posedge clock);
      v = admit_request(r);
      pending_verdicts = {pending_verdicts, (typed ? want : v)};
      sent++;
   endtask

   task automatic wait_idle();
      req_push <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // leaves csr_write_en high; the caller lowers it after the last write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] d);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= d;
      @(posedge clock);
      case (idx)
         CSR_MAX_PER_WINDOW: max_hits = d[7:0];
         CSR_WINDOW_SECONDS: win_len  = d[15:0];
         default: ;
      endcase
   endtask

   // result side: random stalls, plus one long hold-off on request
   initial begin : drain
      int unsigned wait_n;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         wait_n = no_gaps ? 0 : $urandom_range(0, 4);
         if (hold_rsp) begin
            wait_n   = wait_n + HOLD_CYCLES;
            hold_rsp = 1'b0;
         end
         if (wait_n > 0) begin
            rsp_pop <= 1'b0;
            repeat (wait_n) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty !== 1'b0) @(posedge clock);
         check_verdict(rsp_data);
      end
   end

   initial begin : stimulus
      scenario_type sc;
      int unsigned  phase;
      int unsigned  n;
      int unsigned  pool_n;
      logic [7:0]   mx;
      logic [15:0]  win;
      logic [31:0]  base;
      logic [31:0]  t;
      logic [31:0]  step;
      logic [31:0]  pool [8];
      req_type      r;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < PLAN_ROWS; k++) begin
         if (plan[k].kind == ROW_CSR) begin
            wait_idle();
            write_reg(plan[k].idx, plan[k].wdata);
            if (k + 1 == PLAN_ROWS || plan[k + 1].kind != ROW_CSR)
               csr_write_en <= 1'b0;
         end else begin
            offer(plan[k].req, plan[k].typed, plan[k].want);
         end
      end

      phase = 0;
      while (sent < ITEMS_TOTAL) begin
         case (phase)
            0: sc = SC_FILL;
            1: sc = SC_POOL;
            2: sc = SC_HAMMER;
            default: begin
               n  = $urandom_range(0, 9);
               sc = (n == 0) ? SC_FILL : (n <= 2) ? SC_NOISE : SC_POOL;
            end
         endcase

         case ($urandom_range(0, 5))
            0: mx = 8'd0;
            1: mx = 8'd1;
            2: mx = 8'hFF;
            3: mx = 8'($urandom_range(1, 5));
            default: mx = 8'($urandom_range(1, 255));
         endcase
         case ($urandom_range(0, 5))
            0: win = 16'd0;
            1: win = 16'd1;
            2: win = 16'hFFFF;
            3: win = 16'($urandom_range(2, 20));
            default: win = 16'($urandom_range(1, 65535));
         endcase
         if (sc == SC_FILL) win = 16'hFFFF;
         if (sc == SC_HAMMER) begin
            mx  = 8'hFF;
            win = 16'hFFFF;
         end

         wait_idle();
         no_gaps = ($urandom_range(0, 3) == 0);
         write_reg(CSR_MAX_PER_WINDOW, {8'($urandom_range(0, 255)), mx});
         write_reg(CSR_WINDOW_SECONDS, win);
         csr_write_en <= 1'b0;
         // receiver stalls while the sender keeps pushing: input must back up
         if (phase == 1) hold_rsp = 1'b1;

         t = ($urandom_range(0, 1) == 1) ? $urandom
                                         : 32'hFFFF_FFFF - $urandom_range(0, 200);
         case (sc)
            SC_FILL: begin
               // every entry taken, then a few more new sources get refused
               base = $urandom;
               for (int i = 0; i < TABLE_ENTRIES + 6; i++)
                  offer('{base + i, t}, 1'b0, '0);
               offer('{base, t}, 1'b0, '0);
               offer('{base + 32'd100, t + 32'h0001_0000}, 1'b0, '0);
            end
            SC_POOL: begin
               pool_n = $urandom_range(1, 8);
               for (int i = 0; i < 8; i++) pool[i] = $urandom;
               case ($urandom_range(0, 3))
                  0: pool[0] = 32'h0000_0000;
                  1: pool[0] = 32'hFFFF_FFFF;
                  default: ;
               endcase
               n = $urandom_range(30, 80);
               for (int i = 0; i < n; i++) begin
                  case ($urandom_range(0, 7))
                     0, 1: step = 32'd0;
                     2, 3: step = 32'd1;
                     4: step = $urandom_range(0, {16'd0, win_len});
                     5: step = {16'd0, win_len};
                     6: step = (win_len == 0) ? 32'd0 : {16'd0, win_len} - 32'd1;
                     default: step = $urandom;
                  endcase
                  t = t + step;
                  offer('{pool[3'($urandom_range(0, pool_n - 1))], t}, 1'b0, '0);
               end
            end
            SC_HAMMER: begin
               // one source counted all the way to the top limit and past it
               base = $urandom;
               for (int i = 0; i < 258; i++) begin
                  t = t + $urandom_range(0, 1);
                  offer('{base, t}, 1'b0, '0);
               end
            end
            default: begin
               n = $urandom_range(20, 40);
               for (int i = 0; i < n; i++) begin
                  r.source_address = $urandom;
                  r.now_seconds    = $urandom;
                  offer(r, 1'b0, '0);
               end
            end
         endcase
         phase++;
      end

      wait_idle();
      repeat (TABLE_ENTRIES + 16) @(posedge clock);
      if (mismatches == 0 && pending_verdicts.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/fwl_pkg.sv
rtl/fwl_fifo.sv
rtl/fwl_engine.sv
rtl/per_source_fixed_window_limiter_top.sv
tb/per_source_fixed_window_limiter_top_tb.sv
